>>> hw/rtl/bbu_pkg.sv
package bbu_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int ADDR_W    = 19;
  localparam int TDATA_W   = 40;
  localparam int PAD_W     = TDATA_W - WORD_W - ADDR_W;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int LEFT_W    = 7;
  localparam int REP_W     = 8;

  localparam int WPR_REG_W = 7;
  localparam int NP_REG_W  = 4;
  localparam int NR_REG_W  = 11;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORDS_PER_ROW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_INTERLEAVED = 3'd4;

  localparam logic [WPR_REG_W-1:0] RST_WORDS_PER_ROW = 7'd20;
  localparam logic [NP_REG_W-1:0]  RST_PLANE_COUNT   = 4'd5;
  localparam logic [NR_REG_W-1:0]  RST_ROW_COUNT     = 11'd256;

  // header -128: no operation
  localparam logic [BYTE_W-1:0] HDR_NOP = 8'h80;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LITERAL,
    PH_RUN
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TOT1,
    S_TOT2,
    S_PUT,
    S_MPL,
    S_MRW,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic compressed;
    logic keep_interleaved;
  } mode_t;

endpackage

>>> hw/rtl/bbu_cfg.sv
// Register bank with range clamping of the geometry registers.
module bbu_cfg #(
  parameter int MAX_WORDS_PER_ROW = 64,
  parameter int MAX_PLANES        = 8,
  parameter int MAX_ROWS          = 1024,
  parameter int WPR_W             = 7,
  parameter int NP_W              = 4,
  parameter int NR_W              = 11
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [bbu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbu_pkg::CFG_W-1:0]     cfg_data,
  output logic [WPR_W-1:0]              wpr,
  output logic [NP_W-1:0]               np,
  output logic [NR_W-1:0]               nr,
  output bbu_pkg::mode_t                mode
);

  logic [bbu_pkg::WPR_REG_W-1:0] wpr_r;
  logic [bbu_pkg::NP_REG_W-1:0]  np_r;
  logic [bbu_pkg::NR_REG_W-1:0]  nr_r;
  bbu_pkg::mode_t                mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpr_r                   <= bbu_pkg::RST_WORDS_PER_ROW;
      np_r                    <= bbu_pkg::RST_PLANE_COUNT;
      nr_r                    <= bbu_pkg::RST_ROW_COUNT;
      mode_r.compressed       <= 1'b1;
      mode_r.keep_interleaved <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbu_pkg::REG_WORDS_PER_ROW:    wpr_r <= cfg_data[bbu_pkg::WPR_REG_W-1:0];
        bbu_pkg::REG_PLANE_COUNT:      np_r  <= cfg_data[bbu_pkg::NP_REG_W-1:0];
        bbu_pkg::REG_ROW_COUNT:        nr_r  <= cfg_data[bbu_pkg::NR_REG_W-1:0];
        bbu_pkg::REG_COMPRESSED:       mode_r.compressed       <= cfg_data[0];
        bbu_pkg::REG_KEEP_INTERLEAVED: mode_r.keep_interleaved <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp to 1..MAX
  always_comb begin
    if (wpr_r == '0) begin
      wpr = WPR_W'(1);
    end else if (32'(wpr_r) > MAX_WORDS_PER_ROW) begin
      wpr = WPR_W'(MAX_WORDS_PER_ROW);
    end else begin
      wpr = WPR_W'(wpr_r);
    end

    if (np_r == '0) begin
      np = NP_W'(1);
    end else if (32'(np_r) > MAX_PLANES) begin
      np = NP_W'(MAX_PLANES);
    end else begin
      np = NP_W'(np_r);
    end

    if (nr_r == '0) begin
      nr = NR_W'(1);
    end else if (32'(nr_r) > MAX_ROWS) begin
      nr = NR_W'(MAX_ROWS);
    end else begin
      nr = NR_W'(nr_r);
    end
  end

  assign mode = mode_r;

endmodule

>>> hw/rtl/bitplane_body_unpack.sv
// Channel  | Dir | Ports                                     | Contents
// ---------+-----+-------------------------------------------+----------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata/in_tlast     | body byte, tlast = end of chunk
// out      | out | out_tvalid/out_tready/out_tdata/out_tlast | word + address, tlast = image done
// cfg      | in  | cfg_we/cfg_index/cfg_data                 | register writes, no read-back
//
// One request at a time. A header byte is only decoded. A data byte is
// accepted, then plane size and image size are formed on the shared
// multiplier; each byte of the request is then held or dropped, or paired
// into a word (plane and row offsets on the multiplier, then emit).
// Synchronous reset restores register defaults and
// clears decode state. A stalled out channel holds the sequencer in emit only.
module bitplane_body_unpack #(
  parameter int MAX_WORDS_PER_ROW = 64,
  parameter int MAX_PLANES        = 8,
  parameter int MAX_ROWS          = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bbu_pkg::BYTE_W-1:0]    in_tdata,   // [7:0] body_byte
  input  logic                          in_tlast,   // chunk_end
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [bbu_pkg::TDATA_W-1:0]   out_tdata,  // [15:0] out_word, [34:16] out_address
  output logic                          out_tlast,  // image_done
  // configuration
  input  logic                          cfg_we,
  input  logic [bbu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbu_pkg::CFG_W-1:0]     cfg_data
);

  // clamped geometry widths
  localparam int WPR_W = $clog2(MAX_WORDS_PER_ROW + 1);
  localparam int NP_W  = $clog2(MAX_PLANES + 1);
  localparam int NR_W  = $clog2(MAX_ROWS + 1);
  // position counter widths
  localparam int COL_W = (MAX_WORDS_PER_ROW > 1) ? $clog2(MAX_WORDS_PER_ROW) : 1;
  localparam int PL_W  = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // products
  localparam int P_W   = WPR_W + NR_W;           // words per plane
  localparam int TOT_W = P_W + NP_W;             // words per image
  localparam int RA_W  = WPR_W + ROW_W;          // row offset
  localparam int MB_W  = (NR_W > NP_W) ? NR_W : NP_W;
  localparam int MY_W  = P_W + MB_W;
  localparam int SUM_W = ((TOT_W > bbu_pkg::ADDR_W) ? TOT_W : bbu_pkg::ADDR_W) + 1;

  logic [WPR_W-1:0] wpr;
  logic [NP_W-1:0]  np;
  logic [NR_W-1:0]  nr;
  bbu_pkg::mode_t   mode;

  bbu_cfg #(
    .MAX_WORDS_PER_ROW (MAX_WORDS_PER_ROW),
    .MAX_PLANES        (MAX_PLANES),
    .MAX_ROWS          (MAX_ROWS),
    .WPR_W             (WPR_W),
    .NP_W              (NP_W),
    .NR_W              (NR_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wpr       (wpr),
    .np        (np),
    .nr        (nr),
    .mode      (mode)
  );

  // sequencer and decode state
  bbu_pkg::state_t               state_r, state_nxt;
  bbu_pkg::phase_t               phase_r, phase_nxt;
  logic [bbu_pkg::LEFT_W-1:0]    left_r, left_nxt;
  logic [bbu_pkg::BYTE_W-1:0]    held_byte_r, held_byte_nxt;
  logic                          held_valid_r, held_valid_nxt;
  logic [COL_W-1:0]              col_r, col_nxt;
  logic [PL_W-1:0]               plane_r, plane_nxt;
  logic [ROW_W-1:0]              row_r, row_nxt;
  logic [TOT_W-1:0]              ww_r, ww_nxt;
  // current request
  logic [bbu_pkg::BYTE_W-1:0]    byte_r, byte_nxt;
  logic [bbu_pkg::REP_W-1:0]     reps_r, reps_nxt;
  logic                          last_r, last_nxt;
  // multiplier results
  logic [P_W-1:0]                p_r, p_nxt;
  logic [TOT_W-1:0]              total_r, total_nxt;
  logic [TOT_W-1:0]              pa_r, pa_nxt;
  logic [RA_W-1:0]               ra_r, ra_nxt;
  // output register
  logic                          out_valid_r, out_valid_nxt;
  logic [bbu_pkg::WORD_W-1:0]    out_word_r, out_word_nxt;
  logic [bbu_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic                          out_last_r, out_last_nxt;

  // shared multiplier
  logic [P_W-1:0]  mul_a;
  logic [MB_W-1:0] mul_b;
  logic [MY_W-1:0] mul_y;

  always_comb begin
    unique case (state_r)
      bbu_pkg::S_TOT1: begin
        mul_a = P_W'(wpr);
        mul_b = MB_W'(nr);
      end
      bbu_pkg::S_TOT2: begin
        mul_a = p_r;
        mul_b = MB_W'(np);
      end
      bbu_pkg::S_MPL: begin
        mul_a = p_r;
        mul_b = MB_W'(plane_r);
      end
      bbu_pkg::S_MRW: begin
        mul_a = P_W'(wpr);
        mul_b = MB_W'(row_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_y = MY_W'(mul_a) * MY_W'(mul_b);
  end

  logic                         accept;
  logic                         step_done;
  logic                         out_free;
  logic [SUM_W-1:0]             planar_addr;
  logic [SUM_W-1:0]             linear_addr;
  logic [COL_W:0]               col_inc;
  logic [PL_W:0]                plane_inc;
  logic [ROW_W:0]               row_inc;
  logic [bbu_pkg::REP_W-1:0]    reps_in;

  assign in_tready   = (state_r == bbu_pkg::S_IDLE);
  assign accept      = in_tvalid && in_tready;
  assign out_free    = !out_valid_r || out_tready;
  assign planar_addr = SUM_W'(pa_r) + SUM_W'(ra_r) + SUM_W'(col_r);
  assign linear_addr = SUM_W'(ww_r);
  assign col_inc     = (COL_W+1)'(col_r) + (COL_W+1)'(1);
  assign plane_inc   = (PL_W+1)'(plane_r) + (PL_W+1)'(1);
  assign row_inc     = (ROW_W+1)'(row_r) + (ROW_W+1)'(1);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    left_nxt       = left_r;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    col_nxt        = col_r;
    plane_nxt      = plane_r;
    row_nxt        = row_r;
    ww_nxt         = ww_r;
    byte_nxt       = byte_r;
    reps_nxt       = reps_r;
    last_nxt       = last_r;
    p_nxt          = p_r;
    total_nxt      = total_r;
    pa_nxt         = pa_r;
    ra_nxt         = ra_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_word_nxt   = out_word_r;
    out_addr_nxt   = out_addr_r;
    out_last_nxt   = out_last_r;
    step_done      = 1'b0;
    reps_in        = '0;

    unique case (state_r)
      bbu_pkg::S_IDLE: begin
        if (accept) begin
          if (!mode.compressed) begin
            reps_in = bbu_pkg::REP_W'(1);
          end else begin
            unique case (phase_r)
              bbu_pkg::PH_LITERAL: begin
                reps_in = bbu_pkg::REP_W'(1);
                if (left_r == '0) begin
                  phase_nxt = bbu_pkg::PH_HEADER;
                end else begin
                  left_nxt = left_r - bbu_pkg::LEFT_W'(1);
                end
              end
              bbu_pkg::PH_RUN: begin
                reps_in   = bbu_pkg::REP_W'(left_r) + bbu_pkg::REP_W'(1);
                left_nxt  = '0;
                phase_nxt = bbu_pkg::PH_HEADER;
              end
              default: begin
                // header byte: literal count, run count or no-op
                phase_nxt = bbu_pkg::PH_HEADER;
                if (in_tdata < bbu_pkg::HDR_NOP) begin
                  left_nxt  = in_tdata[bbu_pkg::LEFT_W-1:0];
                  phase_nxt = bbu_pkg::PH_LITERAL;
                end else if (in_tdata > bbu_pkg::HDR_NOP) begin
                  left_nxt  = bbu_pkg::LEFT_W'(bbu_pkg::BYTE_W'(0) - in_tdata);
                  phase_nxt = bbu_pkg::PH_RUN;
                end
              end
            endcase
          end
          byte_nxt = in_tdata;
          reps_nxt = reps_in;
          last_nxt = in_tlast;
          if (reps_in != '0) begin
            state_nxt = bbu_pkg::S_TOT1;
          end else if (in_tlast) begin
            phase_nxt      = bbu_pkg::PH_HEADER;
            left_nxt       = '0;
            held_byte_nxt  = '0;
            held_valid_nxt = 1'b0;
            col_nxt        = '0;
            plane_nxt      = '0;
            row_nxt        = '0;
            ww_nxt         = '0;
          end
        end
      end

      bbu_pkg::S_TOT1: begin
        p_nxt     = P_W'(mul_y);
        state_nxt = bbu_pkg::S_TOT2;
      end

      bbu_pkg::S_TOT2: begin
        total_nxt = TOT_W'(mul_y);
        state_nxt = bbu_pkg::S_PUT;
      end

      bbu_pkg::S_PUT: begin
        if (!held_valid_r) begin
          held_byte_nxt  = byte_r;
          held_valid_nxt = 1'b1;
          step_done      = 1'b1;
        end else if (ww_r >= total_r) begin
          // image full: drop the word
          ww_nxt         = total_r;
          held_valid_nxt = 1'b0;
          step_done      = 1'b1;
        end else begin
          state_nxt = bbu_pkg::S_MPL;
        end
      end

      bbu_pkg::S_MPL: begin
        pa_nxt    = TOT_W'(mul_y);
        state_nxt = bbu_pkg::S_MRW;
      end

      bbu_pkg::S_MRW: begin
        ra_nxt    = RA_W'(mul_y);
        state_nxt = bbu_pkg::S_EMIT;
      end

      bbu_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = {held_byte_r, byte_r};
          out_addr_nxt   = mode.keep_interleaved ? linear_addr[bbu_pkg::ADDR_W-1:0]
                                                 : planar_addr[bbu_pkg::ADDR_W-1:0];
          out_last_nxt   = (ww_r + TOT_W'(1)) == total_r;
          ww_nxt         = ww_r + TOT_W'(1);
          held_valid_nxt = 1'b0;
          step_done      = 1'b1;
          // column, then plane, then row
          if (col_inc >= (COL_W+1)'(wpr)) begin
            col_nxt = '0;
            if (plane_inc >= (PL_W+1)'(np)) begin
              plane_nxt = '0;
              if (row_inc >= (ROW_W+1)'(nr)) begin
                row_nxt = '0;
              end else begin
                row_nxt = row_inc[ROW_W-1:0];
              end
            end else begin
              plane_nxt = plane_inc[PL_W-1:0];
            end
          end else begin
            col_nxt = col_inc[COL_W-1:0];
          end
        end
      end

      default: begin
        state_nxt = bbu_pkg::S_IDLE;
      end
    endcase

    if (step_done) begin
      reps_nxt = reps_r - bbu_pkg::REP_W'(1);
      if (reps_r == bbu_pkg::REP_W'(1)) begin
        state_nxt = bbu_pkg::S_IDLE;
        if (last_r) begin
          phase_nxt      = bbu_pkg::PH_HEADER;
          left_nxt       = '0;
          held_byte_nxt  = '0;
          held_valid_nxt = 1'b0;
          col_nxt        = '0;
          plane_nxt      = '0;
          row_nxt        = '0;
          ww_nxt         = '0;
        end
      end else begin
        state_nxt = bbu_pkg::S_PUT;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bbu_pkg::S_IDLE;
      phase_r      <= bbu_pkg::PH_HEADER;
      left_r       <= '0;
      held_valid_r <= 1'b0;
      col_r        <= '0;
      plane_r      <= '0;
      row_r        <= '0;
      ww_r         <= '0;
      reps_r       <= '0;
      last_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      left_r       <= left_nxt;
      held_valid_r <= held_valid_nxt;
      col_r        <= col_nxt;
      plane_r      <= plane_nxt;
      row_r        <= row_nxt;
      ww_r         <= ww_nxt;
      reps_r       <= reps_nxt;
      last_r       <= last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
    byte_r      <= byte_nxt;
    p_r         <= p_nxt;
    total_r     <= total_nxt;
    pa_r        <= pa_nxt;
    ra_r        <= ra_nxt;
    out_word_r  <= out_word_nxt;
    out_addr_r  <= out_addr_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{bbu_pkg::PAD_W{1'b0}}, out_addr_r, out_word_r};
  assign out_tlast  = out_last_r;

endmodule

>>> bench/unpack_check_pkg.sv
package unpack_check_pkg;

  import bbu_pkg::*;

  // block sizing used both for the DUT parameters and the predictor clamps
  localparam int ROW_WORDS_MAX = 64;
  localparam int PLANES_MAX    = 8;
  localparam int ROWS_MAX      = 1024;

  typedef struct packed {
    logic [WORD_W-1:0] data;
    logic [ADDR_W-1:0] addr;
    logic              image_done;
  } plane_word_t;

  class unpack_scoreboard;

    // register copies
    logic [WPR_REG_W-1:0] wpr_reg;
    logic [NP_REG_W-1:0]  np_reg;
    logic [NR_REG_W-1:0]  nr_reg;
    logic                 comp_reg;
    logic                 keep_reg;

    // decoder and placement state
    phase_t              stage;
    logic [LEFT_W-1:0]   bytes_due;
    logic [BYTE_W-1:0]   held;
    logic                half_held;
    logic [5:0]          col;
    logic [2:0]          pln;
    logic [9:0]          row;
    int unsigned         written;  // wider than the block's 22-bit word count, never reaches 2^19 here

    plane_word_t due_words[$];
    int unsigned bytes_taken;
    int unsigned words_checked;
    int unsigned bad_words;

    function new();
      wpr_reg  = RST_WORDS_PER_ROW;
      np_reg   = RST_PLANE_COUNT;
      nr_reg   = RST_ROW_COUNT;
      comp_reg = 1'b1;
      keep_reg = 1'b0;
      clear_position();
    endfunction

    function void clear_position();
      stage     = PH_HEADER;
      bytes_due = '0;
      held      = '0;
      half_held = 1'b0;
      col       = '0;
      pln       = '0;
      row       = '0;
      written   = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_WORDS_PER_ROW:    wpr_reg  = val[WPR_REG_W-1:0];
        REG_PLANE_COUNT:      np_reg   = val[NP_REG_W-1:0];
        REG_ROW_COUNT:        nr_reg   = val[NR_REG_W-1:0];
        REG_COMPRESSED:       comp_reg = val[0];
        REG_KEEP_INTERLEAVED: keep_reg = val[0];
        default: ;
      endcase
    endfunction

    // one data byte into the word pairer; second byte of a pair may yield a word
    function void pair_byte(logic [BYTE_W-1:0] b);
      int unsigned wpr;
      int unsigned np;
      int unsigned nr;
      int unsigned total;
      plane_word_t w;
      if (!half_held) begin
        held      = b;
        half_held = 1'b1;
        return;
      end
      half_held = 1'b0;
      wpr   = clamp(wpr_reg, ROW_WORDS_MAX);
      np    = clamp(np_reg, PLANES_MAX);
      nr    = clamp(nr_reg, ROWS_MAX);
      total = wpr * np * nr;
      if (written >= total) begin
        written = total;  // past the image: dropped
        return;
      end
      w.data = {held, b};
      if (keep_reg)
        w.addr = ADDR_W'(written);
      else
        w.addr = ADDR_W'(pln * wpr * nr + row * wpr + col);
      w.image_done = (written + 1 == total);
      due_words.push_back(w);
      written++;
      if (col + 1 >= wpr) begin
        col = '0;
        if (pln + 1 >= np) begin
          pln = '0;
          if (row + 1 >= nr) row = '0;
          else row++;
        end else begin
          pln++;
        end
      end else begin
        col++;
      end
    endfunction

    function void take_byte(logic [BYTE_W-1:0] b, logic chunk_end);
      bytes_taken++;
      if (!comp_reg) begin
        pair_byte(b);
      end else begin
        case (stage)
          PH_LITERAL: begin
            pair_byte(b);
            if (bytes_due == 0) stage = PH_HEADER;
            else bytes_due--;
          end
          PH_RUN: begin
            for (int i = 0; i <= bytes_due; i++) pair_byte(b);
            bytes_due = '0;
            stage     = PH_HEADER;
          end
          default: begin
            stage = PH_HEADER;
            if (b < HDR_NOP) begin
              bytes_due = b[LEFT_W-1:0];
              stage     = PH_LITERAL;
            end else if (b > HDR_NOP) begin
              bytes_due = LEFT_W'(9'd256 - b);  // run of 257-b bytes
              stage     = PH_RUN;
            end
          end
        endcase
      end
      if (chunk_end) clear_position();
    endfunction

    function void match_word(logic [WORD_W-1:0] data, logic [ADDR_W-1:0] addr,
                             logic done);
      plane_word_t want;
      words_checked++;
      if (due_words.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word %h addr %h done %b", data, addr, done);
        return;
      end
      want = due_words.pop_front();
      if (want.data !== data || want.addr !== addr || want.image_done !== done) begin
        bad_words++;
        if (bad_words <= 10)
          $display("word mismatch: expected %h addr %h done %b, got %h addr %h done %b",
                   want.data, want.addr, want.image_done, data, addr, done);
      end
    endfunction

    function int unsigned words_due();
      return due_words.size();
    endfunction

    function bit clean();
      return bad_words == 0 && due_words.size() == 0;
    endfunction

  endclass

endpackage

>>> bench/bitplane_body_unpack_test.sv
module bitplane_body_unpack_test;

  timeunit 1ns;
  timeprecision 1ps;

  import bbu_pkg::*;
  import unpack_check_pkg::*;

  // run shape
  localparam int PHASES          = 8;
  localparam int BYTES_PER_PHASE = 48;
  // time for a dropped 128-byte run to drain after the last word
  localparam int QUIET_CYCLES    = 300;
  localparam int unsigned LIMIT  = 2_000_000;

  // opening requests: {chunk_end, body_byte}
  localparam logic [8:0] OPENING [23] = '{
    9'h001, 9'h000, 9'h0FF,          // literal of two bytes, both byte extremes
    9'h080,                          // header -128 does nothing
    9'h081, 9'h0A5,                  // longest run, 128 bytes -> 64 words
    9'h0FF, 9'h05A,                  // shortest run, 2 bytes
    9'h0FE, 9'h03C,                  // 3-byte run leaves a half word held
    9'h000, 9'h0C3,                  // single literal completes that half word
    9'h0FE, 9'h111,                  // run with chunk end, odd byte thrown away
    9'h07F, 9'h012, 9'h034, 9'h156,  // longest literal cut short by chunk end
    9'h180,                          // no-op header carrying chunk end
    9'h002, 9'h001, 9'h080, 9'h17F   // literal whose data looks like headers
  };

  logic                 clk;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata   = '0;  // [7:0] body_byte
  logic                 in_tlast   = 1'b0; // chunk_end
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [TDATA_W-1:0]   out_tdata;        // [15:0] out_word, [34:16] out_address
  logic                 out_tlast;        // image_done
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [CFG_W-1:0]     cfg_data   = '0;

  // idling odds in percent, changed per phase
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;
  int unsigned cycles    = 0;
  int unsigned settings_used = 0;

  unpack_scoreboard board = new();

  bitplane_body_unpack #(
    .MAX_WORDS_PER_ROW(ROW_WORDS_MAX),
    .MAX_PLANES       (PLANES_MAX),
    .MAX_ROWS         (ROWS_MAX)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d words still due", cycles, board.words_due());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: check what was taken at this edge, then pick next ready.
  // Values read here are the pre-edge ones, so no ordering race with the DUT.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.match_word(out_tdata[WORD_W-1:0], out_tdata[WORD_W +: ADDR_W], out_tlast);
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // one body byte; valid stays high straight into the next request
  // unless a gap is drawn, so valid never gets two updates in one step
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic chunk_end);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= chunk_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.take_byte(b, chunk_end);
  endtask

  // all five registers back to back, plus a write to an unused index,
  // which the block must ignore
  task automatic load_registers(input logic [CFG_W-1:0] wpr, np, nr,
                                input logic comp, keep);
    logic [CFG_IDX_W-1:0] regs [5];
    logic [CFG_W-1:0]     vals [5];
    logic [CFG_IDX_W-1:0] spare;
    regs  = '{REG_WORDS_PER_ROW, REG_PLANE_COUNT, REG_ROW_COUNT,
              REG_COMPRESSED, REG_KEEP_INTERLEAVED};
    vals  = '{wpr, np, nr, CFG_W'(comp), CFG_W'(keep)};
    spare = REG_KEEP_INTERLEAVED + CFG_IDX_W'($urandom_range(1, 3));
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      board.write_reg(regs[i], vals[i]);
    end
    cfg_index <= spare;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 63; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 63; end
      default: begin gap_pct = 7; stall_pct = 7; end
    endcase
  endtask

  // wait out every due word, then the block's tail of held or dropped bytes
  task automatic settle();
    while (board.words_due() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed packets with random payload: literals (usually short,
  // now and then long), runs of any length, no-op headers; the rest is stray
  // bytes and chunk ends dropped mid-packet.
  task automatic stream_body(input int unsigned target);
    int unsigned start;
    int unsigned kind;
    int unsigned len;
    logic        ends_chunk;
    start = board.bytes_taken;
    while (board.bytes_taken - start < target) begin
      kind       = $urandom_range(99);
      ends_chunk = ($urandom_range(99) < 8);
      if (kind < 45) begin
        len = ($urandom_range(9) != 0) ? $urandom_range(1, 12) : $urandom_range(13, 128);
        send_byte(BYTE_W'(len - 1), 1'b0);
        for (int j = 0; j < len; j++)
          send_byte(BYTE_W'($urandom),
                    (ends_chunk && j == len - 1) || $urandom_range(99) < 2);
      end else if (kind < 80) begin
        send_byte(BYTE_W'($urandom_range(HDR_NOP + 1, 8'hFF)), 1'b0);
        send_byte(BYTE_W'($urandom), ends_chunk);
      end else if (kind < 85) begin
        send_byte(HDR_NOP, ends_chunk);
      end else begin
        send_byte(BYTE_W'($urandom), $urandom_range(99) < 5);
      end
    end
    in_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests on the reset settings (run-length, planar 20x5x256)
    settings_used = 1;
    set_idling(3);
    foreach (OPENING[k])
      send_byte(OPENING[k][7:0], OPENING[k][8]);
    in_tvalid <= 1'b0;
    settle();

    // Random phases. Position counters carry over between phases unless a
    // chunk end came last, so shrinking the image also exercises counter wrap.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: load_registers(CFG_W'(1), CFG_W'(1), CFG_W'(1), 1'b1, 1'b0);        // one-word image
        1: load_registers(CFG_W'(64), CFG_W'(8), CFG_W'(1024), 1'b1, 1'b1);    // largest image
        2: load_registers(CFG_W'(0), CFG_W'(0), CFG_W'(0), 1'b0, 1'b1);        // zeros clamp to 1
        3: load_registers(CFG_W'(127), CFG_W'(15), CFG_W'(2047), 1'b0, 1'b0);  // clamp to max
        default: begin
          if ($urandom_range(3) == 0)
            load_registers(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                           1'($urandom), 1'($urandom));
          else  // small images so image_done and overflow come often
            load_registers(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 4)),
                           CFG_W'($urandom_range(1, 3)), 1'($urandom_range(3) != 0),
                           1'($urandom));
        end
      endcase
      set_idling(p % 4);
      stream_body(BYTES_PER_PHASE);
      settle();
    end

    $display("%0d body bytes over %0d register settings, all four idling modes",
             board.bytes_taken, settings_used);
    $display("%0d words checked, %0d bad, %0d still due",
             board.words_checked, board.bad_words, board.words_due());
    if (board.clean())
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> bitplane_body_unpack.f
hw/rtl/bbu_pkg.sv
hw/rtl/bbu_cfg.sv
hw/rtl/bitplane_body_unpack.sv
bench/unpack_check_pkg.sv
bench/bitplane_body_unpack_test.sv
